@@ sv/tsf_pkg.sv @@
// Shared types, constants and header tables for the tape sector framer.
`timescale 1ns / 1ps
`default_nettype none
package tsf_pkg;

  localparam logic [13:0] HEADER_LEADER_CYCLES = 14'd10240;
  localparam logic [13:0] PRE_DATA_CYCLES      = 14'd5120;
  localparam logic [13:0] POST_CYCLES          = 14'd5;
  localparam logic [15:0] CRC_POLY             = 16'h0810;

  localparam logic [4:0] HDR_LAST_IDX  = 5'd26;
  localparam logic [2:0] DHDR_LAST_IDX = 3'd5;

  // Configuration register indexes.
  localparam logic [1:0] CFG_FILE_TYPE  = 2'd0;
  localparam logic [1:0] CFG_TOTAL_SIZE = 2'd1;
  localparam logic [1:0] CFG_AUTOSTART  = 2'd2;

  localparam logic REQ_START   = 1'b0;
  localparam logic REQ_PAYLOAD = 1'b1;

  typedef enum logic [1:0] {
    KIND_BYTE    = 2'd0,
    KIND_TONE    = 2'd1,
    KIND_SYNC    = 2'd2,
    KIND_SILENCE = 2'd3
  } kind_t;

  typedef enum logic [4:0] {
    PH_IDLE,
    PH_SIL2,
    PH_LEADER,
    PH_SYNC1,
    PH_HDR,
    PH_HCRC_LO,
    PH_HCRC_HI,
    PH_POST1,
    PH_SIL1,
    PH_PRE,
    PH_SYNC2,
    PH_DHDR,
    PH_SECNUM,
    PH_SECLEN,
    PH_DATA,
    PH_MARK,
    PH_CRC_LO,
    PH_CRC_HI,
    PH_POST2,
    PH_SIL_END
  } phase_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  byte_value;
    logic [13:0] repeat_count;
    logic        last;
  } res_t;

  // Bytes of the 27-byte header block body (the CRC follows it).
  function automatic logic [7:0] hdr_byte(input logic [4:0] idx, input logic [7:0] ftype,
                                          input logic [15:0] size, input logic [7:0] astart);
    logic [7:0] b;
    b = 8'h00;
    case (idx)
      5'd1:    b = 8'h6a;
      5'd2:    b = 8'hff;
      5'd3:    b = 8'h11;
      5'd5:    b = 8'h01;
      5'd7:    b = 8'h12;
      5'd8:    b = 8'h01;
      5'd9:    b = 8'h20;
      5'd11:   b = ftype;
      5'd12:   b = size[7:0];
      5'd13:   b = size[15:8];
      5'd14:   b = astart;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  // Bytes of the data block header; the last one is the sector count.
  function automatic logic [7:0] dhdr_byte(input logic [2:0] idx, input logic [15:0] size);
    logic [7:0] b;
    b = 8'h00;
    case (idx)
      3'd1:    b = 8'h6a;
      3'd3:    b = 8'h11;
      3'd5:    b = size[15:8] + {7'd0, |size[7:0]};
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage
`default_nettype wire

@@ sv/tsf_crc.sv @@
// One-byte update of the tape sector CRC, bits taken LSB first.
`timescale 1ns / 1ps
`default_nettype none
module tsf_crc (
  input  wire logic [15:0] crc,
  input  wire logic [7:0]  data,
  output logic      [15:0] crc_next
);

  always_comb begin
    logic [15:0] c;
    logic        fb;
    c = crc;
    for (int b = 0; b < 8; b++) begin
      fb = data[b] ^ c[15];
      if (fb) begin
        c = c ^ tsf_pkg::CRC_POLY;
      end
      c = {c[14:0], fb};
    end
    crc_next = c;
  end

endmodule
`default_nettype wire

@@ sv/tsf_out.sv @@
// Two-entry result buffer that decouples the sequencer from the output handshake.
`timescale 1ns / 1ps
`default_nettype none
module tsf_out (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire tsf_pkg::res_t wdata,
  output logic               space,
  output logic               out_valid,
  input  wire logic          out_ready,
  output tsf_pkg::res_t      head
);

  tsf_pkg::res_t slot0;
  tsf_pkg::res_t slot1;
  logic [1:0]    cnt;
  logic          pop;

  assign out_valid = (cnt != 2'd0);
  assign space     = (cnt != 2'd2);
  assign pop       = out_valid && out_ready;
  assign head      = slot0;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else begin
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (pop && cnt == 2'd2) begin
      slot0 <= slot1;
    end
    if (push) begin
      if (cnt == 2'd0 || (cnt == 2'd1 && pop)) begin
        slot0 <= wdata;
      end else begin
        slot1 <= wdata;
      end
    end
  end

endmodule
`default_nettype wire

@@ sv/tsf_seq.sv @@
// Sequencer that turns start and payload words into the framed tape result stream.
`timescale 1ns / 1ps
`default_nettype none
module tsf_seq (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic [7:0]    file_type,
  input  wire logic [15:0]   total_size,
  input  wire logic [7:0]    autostart,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic          req_type,
  input  wire logic [7:0]    data_byte,
  input  wire logic          space,
  output logic               push,
  output tsf_pkg::res_t      res
);

  tsf_pkg::phase_t phase;
  tsf_pkg::phase_t phase_step;
  logic [4:0]      cnt;
  logic [4:0]      cnt_next;
  logic [15:0]     crc;
  logic [15:0]     crc_next;
  logic [15:0]     crc_fed;
  logic            feed;
  logic [8:0]      sec_left;
  logic [8:0]      sec_left_next;
  logic [15:0]     pay_left;
  logic [15:0]     pay_left_next;
  logic [7:0]      sec_num;
  logic [7:0]      sec_num_next;
  logic            active;
  logic            active_next;
  logic            final_sec;
  logic            final_sec_next;
  logic [7:0]      data_reg;
  logic            emit;
  logic            fire;
  logic            accept;
  logic            pay_ok;

  tsf_crc u_crc (
    .crc      (crc),
    .data     (res.byte_value),
    .crc_next (crc_fed)
  );

  assign pay_ok = active && (sec_left != 9'd0) && (pay_left != 16'd0);
  assign fire   = (phase != tsf_pkg::PH_IDLE) && space;
  // A new word enters in the cycle the current one produces its last result.
  assign in_ready = (phase == tsf_pkg::PH_IDLE) ||
                    (space && phase_step == tsf_pkg::PH_IDLE);
  assign accept = in_valid && in_ready;
  assign push   = fire && emit;

  always_comb begin
    phase_step     = phase;
    cnt_next       = cnt;
    crc_next       = crc;
    feed           = 1'b0;
    sec_left_next  = sec_left;
    pay_left_next  = pay_left;
    sec_num_next   = sec_num;
    active_next    = active;
    final_sec_next = final_sec;
    emit           = 1'b1;
    res.kind         = tsf_pkg::KIND_BYTE;
    res.byte_value   = 8'h00;
    res.repeat_count = 14'd1;
    unique case (phase)
      tsf_pkg::PH_IDLE: begin
        emit = 1'b0;
      end
      tsf_pkg::PH_SIL2: begin
        res.kind         = tsf_pkg::KIND_SILENCE;
        res.repeat_count = 14'd2;
        active_next      = 1'b1;
        pay_left_next    = total_size;
        sec_num_next     = 8'd1;
        crc_next         = 16'd0;
        phase_step       = tsf_pkg::PH_LEADER;
      end
      tsf_pkg::PH_LEADER: begin
        res.kind         = tsf_pkg::KIND_TONE;
        res.repeat_count = tsf_pkg::HEADER_LEADER_CYCLES;
        phase_step       = tsf_pkg::PH_SYNC1;
      end
      tsf_pkg::PH_SYNC1: begin
        res.kind   = tsf_pkg::KIND_SYNC;
        cnt_next   = 5'd0;
        phase_step = tsf_pkg::PH_HDR;
      end
      tsf_pkg::PH_HDR: begin
        res.byte_value = tsf_pkg::hdr_byte(cnt, file_type, total_size, autostart);
        feed           = 1'b1;
        cnt_next       = cnt + 5'd1;
        if (cnt == tsf_pkg::HDR_LAST_IDX) begin
          phase_step = tsf_pkg::PH_HCRC_LO;
        end
      end
      tsf_pkg::PH_HCRC_LO: begin
        res.byte_value = crc[7:0];
        phase_step     = tsf_pkg::PH_HCRC_HI;
      end
      tsf_pkg::PH_HCRC_HI: begin
        res.byte_value = crc[15:8];
        phase_step     = tsf_pkg::PH_POST1;
      end
      tsf_pkg::PH_POST1: begin
        res.kind         = tsf_pkg::KIND_TONE;
        res.repeat_count = tsf_pkg::POST_CYCLES;
        phase_step       = tsf_pkg::PH_SIL1;
      end
      tsf_pkg::PH_SIL1: begin
        res.kind   = tsf_pkg::KIND_SILENCE;
        phase_step = tsf_pkg::PH_PRE;
      end
      tsf_pkg::PH_PRE: begin
        res.kind         = tsf_pkg::KIND_TONE;
        res.repeat_count = tsf_pkg::PRE_DATA_CYCLES;
        phase_step       = tsf_pkg::PH_SYNC2;
      end
      tsf_pkg::PH_SYNC2: begin
        res.kind   = tsf_pkg::KIND_SYNC;
        crc_next   = 16'd0;
        cnt_next   = 5'd0;
        phase_step = tsf_pkg::PH_DHDR;
      end
      tsf_pkg::PH_DHDR: begin
        res.byte_value = tsf_pkg::dhdr_byte(cnt[2:0], total_size);
        feed           = 1'b1;
        cnt_next       = cnt + 5'd1;
        if (cnt[2:0] == tsf_pkg::DHDR_LAST_IDX) begin
          phase_step = tsf_pkg::PH_SECNUM;
        end
      end
      tsf_pkg::PH_SECNUM: begin
        res.byte_value = sec_num;
        feed           = 1'b1;
        sec_num_next   = sec_num + 8'd1;
        // A sector shorter than 256 bytes, empty included, is the final one.
        if (|pay_left[15:8]) begin
          sec_left_next  = 9'd256;
          final_sec_next = 1'b0;
        end else begin
          sec_left_next  = {1'b0, pay_left[7:0]};
          final_sec_next = 1'b1;
        end
        phase_step = tsf_pkg::PH_SECLEN;
      end
      tsf_pkg::PH_SECLEN: begin
        res.byte_value = sec_left[7:0];
        feed           = 1'b1;
        phase_step     = (sec_left != 9'd0) ? tsf_pkg::PH_IDLE : tsf_pkg::PH_MARK;
      end
      tsf_pkg::PH_DATA: begin
        if (pay_ok) begin
          res.byte_value = data_reg;
          feed           = 1'b1;
          sec_left_next  = sec_left - 9'd1;
          pay_left_next  = pay_left - 16'd1;
          phase_step     = (sec_left == 9'd1) ? tsf_pkg::PH_MARK : tsf_pkg::PH_IDLE;
        end else begin
          emit       = 1'b0;
          phase_step = tsf_pkg::PH_IDLE;
        end
      end
      tsf_pkg::PH_MARK: begin
        res.byte_value = (final_sec || pay_left == 16'd0) ? 8'hff : 8'h00;
        feed           = 1'b1;
        phase_step     = tsf_pkg::PH_CRC_LO;
      end
      tsf_pkg::PH_CRC_LO: begin
        res.byte_value = crc[7:0];
        phase_step     = tsf_pkg::PH_CRC_HI;
      end
      tsf_pkg::PH_CRC_HI: begin
        res.byte_value = crc[15:8];
        if (final_sec) begin
          phase_step = tsf_pkg::PH_POST2;
        end else begin
          crc_next   = 16'd0;
          phase_step = tsf_pkg::PH_SECNUM;
        end
      end
      tsf_pkg::PH_POST2: begin
        res.kind         = tsf_pkg::KIND_TONE;
        res.repeat_count = tsf_pkg::POST_CYCLES;
        phase_step       = tsf_pkg::PH_SIL_END;
      end
      tsf_pkg::PH_SIL_END: begin
        res.kind      = tsf_pkg::KIND_SILENCE;
        active_next   = 1'b0;
        sec_left_next = 9'd0;
        phase_step    = tsf_pkg::PH_IDLE;
      end
      default: begin
        emit       = 1'b0;
        phase_step = tsf_pkg::PH_IDLE;
      end
    endcase
    res.last = (phase_step == tsf_pkg::PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= tsf_pkg::PH_IDLE;
      cnt       <= 5'd0;
      crc       <= 16'd0;
      sec_left  <= 9'd0;
      pay_left  <= 16'd0;
      sec_num   <= 8'd1;
      active    <= 1'b0;
      final_sec <= 1'b0;
    end else begin
      if (fire) begin
        cnt       <= cnt_next;
        crc       <= feed ? crc_fed : crc_next;
        sec_left  <= sec_left_next;
        pay_left  <= pay_left_next;
        sec_num   <= sec_num_next;
        active    <= active_next;
        final_sec <= final_sec_next;
      end
      if (accept) begin
        phase <= (req_type == tsf_pkg::REQ_START) ? tsf_pkg::PH_SIL2 : tsf_pkg::PH_DATA;
      end else if (fire) begin
        phase <= phase_step;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && req_type == tsf_pkg::REQ_PAYLOAD) begin
      data_reg <= data_byte;
    end
  end

endmodule
`default_nettype wire

@@ sv/tape_sector_framer_crc.sv @@
// Top level of the tape sector framer: configuration registers, sequencer and output buffer.
// The block produces one result word per clock while the output side takes them. A payload
// word yields one framed byte; the word that closes a sector also yields the mark and CRC,
// then the next sector's number and size or, at the end of the file, the closing tone and
// silence. A start word yields the lead-in, header block and data block header (and the
// closing when the file size is zero). Results come one per cycle while the output buffer
// has space; the next input word is taken in the cycle the current word's last result is
// produced. The two-word output buffer absorbs a result after the output side stalls. The
// sequencer reads the configuration registers while it lays out a start word, so writes
// must be made while no word is in flight; they apply at the next start word.
`timescale 1ns / 1ps
`default_nettype none
module tape_sector_framer_crc (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        req_type,
  input  wire logic [7:0]  data_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       kind,
  output logic [7:0]       byte_value,
  output logic [13:0]      repeat_count,
  output logic             last
);

  logic [7:0]    file_type;
  logic [15:0]   total_size;
  logic [7:0]    autostart;
  logic          space;
  logic          push;
  tsf_pkg::res_t res;
  tsf_pkg::res_t head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      file_type  <= 8'd0;
      total_size <= 16'd0;
      autostart  <= 8'd0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        tsf_pkg::CFG_FILE_TYPE:  file_type  <= cfg_data[7:0];
        tsf_pkg::CFG_TOTAL_SIZE: total_size <= cfg_data;
        tsf_pkg::CFG_AUTOSTART:  autostart  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  tsf_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .file_type  (file_type),
    .total_size (total_size),
    .autostart  (autostart),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .req_type   (req_type),
    .data_byte  (data_byte),
    .space      (space),
    .push       (push),
    .res        (res)
  );

  tsf_out u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .wdata     (res),
    .space     (space),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head)
  );

  assign kind         = head.kind;
  assign byte_value   = head.byte_value;
  assign repeat_count = head.repeat_count;
  assign last         = head.last;

endmodule
`default_nettype wire
